/* rtl/lphm_pkg.sv */
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared types and codes for the linear-probe hash map: request, response and
// slot payloads, operation and status codes, hash step codes, size reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package lphm_pkg;

	// operation codes
	localparam logic [1:0] FUNC_LOOKUP = 2'd0;
	localparam logic [1:0] FUNC_INSERT = 2'd1;
	localparam logic [1:0] FUNC_REMOVE = 2'd2;

	// status codes
	localparam logic [2:0] STAT_NONE    = 3'd0;
	localparam logic [2:0] STAT_UPDATED = 3'd1;
	localparam logic [2:0] STAT_ADDED   = 3'd2;
	localparam logic [2:0] STAT_FOUND   = 3'd3;
	localparam logic [2:0] STAT_REMOVED = 3'd4;

	// hash sequence, one shared add/xor pass per step
	localparam logic [2:0] HS_INV_ADD18 = 3'd0;
	localparam logic [2:0] HS_XOR_SAR31 = 3'd1;
	localparam logic [2:0] HS_MUL3      = 3'd2;
	localparam logic [2:0] HS_MUL7      = 3'd3;
	localparam logic [2:0] HS_XOR_SAR11 = 3'd4;
	localparam logic [2:0] HS_ADD_SHL6  = 3'd5;
	localparam logic [2:0] HS_XOR_SAR22 = 3'd6;

	// size register reset value
	localparam logic [3:0] SIZE_LOG2_RESET = 4'd10;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] key;
		logic [63:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] found_value;
		logic [10:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [31:0] hash;
		logic [63:0] key;
		logic [63:0] value;
	} slot_t;

endpackage

`default_nettype wire

/* rtl/lphm_ram.sv */
// ----------------------------------------------------------------------------
// lphm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lphm_ram #(
	parameter int WIDTH = 160,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/linear_probe_hash_map_top.sv */
// ----------------------------------------------------------------------------
// linear_probe_hash_map_top
// Open-addressing key/value map with linear probing over one slot RAM.
// The key is hashed step by step in the shared add/xor unit, then slots are
// probed from the masked hash until a hit or MAX_PROBES slots are checked;
// a zero hash or unused op ends without probing. No new request is taken
// until the last is done: busy is high throughout, and the slot RAM's single
// read port (one probe per cycle) sets the probe time. Reset: an async reset
// clears all slots, busy high. done is a one-cycle strobe, never stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_map_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int MAX_PROBES  = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire lphm_pkg::req_t  req,
	output logic                 done,
	output lphm_pkg::rsp_t       rsp,
	input  wire logic            cfg_wr_en,
	input  wire logic [3:0]      cfg_wr_data
);

	localparam int AW    = $clog2(TABLE_DEPTH);
	localparam int PW    = $clog2(MAX_PROBES + 1);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [15:0] MAX_MASK = 16'(TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_HASH  = 4'b0100,
		S_PROBE = 4'b1000
	} state_t;

	state_t              state_q;
	logic [3:0]          size_log2_q;
	logic [AW-1:0]       clr_q;
	logic [2:0]          step_q;
	logic [63:0]         acc_q;
	logic [1:0]          func_q;
	logic [63:0]         key_q;
	logic [63:0]         value_q;
	logic [31:0]         hash_q;
	logic [AW-1:0]       idx_q;
	logic [PW-1:0]       issue_cnt_q;
	logic [PW-1:0]       chk_cnt_q;
	logic                vld_s1;
	logic [AW-1:0]       addr_s1;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;
	logic [2:0]          status_q;
	logic [63:0]         fv_q;

	logic [3:0]          lg;
	logic [15:0]         mask16;
	logic [AW-1:0]       mask;
	logic [63:0]         hash_nxt;
	logic                func_ok;
	logic                rd_en;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	lphm_pkg::slot_t     ram_wdata;
	lphm_pkg::slot_t     ram_rdata;
	logic                slot_match;
	logic                slot_empty;
	logic                hit;
	logic                probe_fail;
	logic [CNT_W+10:0]   cnt_ext;

	// one pass of the shared add/xor unit
	function automatic logic [63:0] hash_step(input logic [63:0] x, input logic [2:0] step);
		logic [63:0] opa;
		logic [63:0] opb;
		logic        cin;
		logic        use_xor;
		opa     = x;
		opb     = '0;
		cin     = 1'b0;
		use_xor = 1'b0;
		case (step)
			lphm_pkg::HS_INV_ADD18: begin
				opa = ~x;
				opb = x << 18;
			end
			lphm_pkg::HS_XOR_SAR31: begin
				opb     = 64'($signed(x) >>> 31);
				use_xor = 1'b1;
			end
			lphm_pkg::HS_MUL3: begin
				opb = x << 1;
			end
			lphm_pkg::HS_MUL7: begin
				// 8x - x
				opa = x << 3;
				opb = ~x;
				cin = 1'b1;
			end
			lphm_pkg::HS_XOR_SAR11: begin
				opb     = 64'($signed(x) >>> 11);
				use_xor = 1'b1;
			end
			lphm_pkg::HS_ADD_SHL6: begin
				opb = x << 6;
			end
			lphm_pkg::HS_XOR_SAR22: begin
				opb     = 64'($signed(x) >>> 22);
				use_xor = 1'b1;
			end
			default: begin
				opb = '0;
			end
		endcase
		return use_xor ? (opa ^ opb) : (opa + opb + 64'(cin));
	endfunction

	// index mask from the size register, clamped both ways
	always_comb begin
		lg     = (size_log2_q < 4'd4) ? 4'd4 : size_log2_q;
		mask16 = 16'((17'd1 << lg) - 17'd1);
		if (mask16 > MAX_MASK) begin
			mask16 = MAX_MASK;
		end
		mask = mask16[AW-1:0];
	end

	assign hash_nxt = hash_step(acc_q, step_q);
	assign func_ok  = (func_q == lphm_pkg::FUNC_LOOKUP) || (func_q == lphm_pkg::FUNC_INSERT) ||
	                  (func_q == lphm_pkg::FUNC_REMOVE);

	assign rd_en = (state_q == S_PROBE) && (issue_cnt_q < PW'(MAX_PROBES));

	assign slot_match = (ram_rdata.hash == hash_q) && (ram_rdata.key == key_q);
	assign slot_empty = (ram_rdata.hash == 32'd0);

	always_comb begin
		hit = 1'b0;
		if (state_q == S_PROBE && vld_s1) begin
			if (func_q == lphm_pkg::FUNC_INSERT) begin
				hit = slot_empty || slot_match;
			end else begin
				hit = slot_match;
			end
		end
	end

	assign probe_fail = (state_q == S_PROBE) && vld_s1 && !hit &&
	                    (chk_cnt_q == PW'(MAX_PROBES - 1));

	// write port: clearing pass or the hit slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == S_CLEAR) begin
			ram_we = 1'b1;
		end else if (hit && func_q != lphm_pkg::FUNC_LOOKUP) begin
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			if (func_q == lphm_pkg::FUNC_INSERT) begin
				ram_wdata.hash  = hash_q;
				ram_wdata.key   = key_q;
				ram_wdata.value = value_q;
			end
		end
	end

	lphm_ram #(
		.WIDTH($bits(lphm_pkg::slot_t)),
		.DEPTH(TABLE_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= lphm_pkg::SIZE_LOG2_RESET;
		end else if (cfg_wr_en) begin
			size_log2_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			step_q      <= '0;
			issue_cnt_q <= '0;
			chk_cnt_q   <= '0;
			vld_s1      <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			vld_s1 <= rd_en && !hit;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						step_q  <= lphm_pkg::HS_INV_ADD18;
						state_q <= S_HASH;
					end
				end
				S_HASH: begin
					step_q <= step_q + 3'd1;
					if (step_q == lphm_pkg::HS_XOR_SAR22) begin
						issue_cnt_q <= '0;
						chk_cnt_q   <= '0;
						if (hash_nxt[31:0] == 32'd0 || !func_ok) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (rd_en) begin
						issue_cnt_q <= issue_cnt_q + PW'(1);
					end
					if (vld_s1) begin
						chk_cnt_q <= chk_cnt_q + PW'(1);
					end
					if (hit) begin
						if (func_q == lphm_pkg::FUNC_INSERT && slot_empty) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end else if (func_q == lphm_pkg::FUNC_REMOVE) begin
							cnt_q <= cnt_q - CNT_W'(1);
						end
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (probe_fail) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					func_q  <= req.func;
					key_q   <= req.key;
					value_q <= req.value;
					acc_q   <= req.key;
				end
			end
			S_HASH: begin
				acc_q <= hash_nxt;
				if (step_q == lphm_pkg::HS_XOR_SAR22) begin
					hash_q   <= hash_nxt[31:0];
					idx_q    <= hash_nxt[AW-1:0] & mask;
					status_q <= lphm_pkg::STAT_NONE;
					fv_q     <= '0;
				end
			end
			S_PROBE: begin
				if (rd_en) begin
					idx_q   <= (idx_q + AW'(1)) & mask;
					addr_s1 <= idx_q;
				end
				if (hit) begin
					case (func_q)
						lphm_pkg::FUNC_LOOKUP: begin
							status_q <= lphm_pkg::STAT_FOUND;
							fv_q     <= ram_rdata.value;
						end
						lphm_pkg::FUNC_INSERT: begin
							status_q <= slot_empty ? lphm_pkg::STAT_ADDED
							                       : lphm_pkg::STAT_UPDATED;
						end
						lphm_pkg::FUNC_REMOVE: begin
							status_q <= lphm_pkg::STAT_REMOVED;
						end
						default: begin
							status_q <= lphm_pkg::STAT_NONE;
						end
					endcase
				end
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	assign cnt_ext = {11'd0, cnt_q};

	assign busy             = (state_q != S_IDLE);
	assign done             = done_q;
	assign rsp.status       = status_q;
	assign rsp.found_value  = fv_q;
	assign rsp.entry_count  = cnt_ext[10:0];

endmodule

`default_nettype wire
